[rtl/bhq_pkg.sv]
// Shared types, constants and control encodings for the binary min-heap queue.
package bhq_pkg;

  // Heap sizing and field widths.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_BITS = 32;
  localparam int TAG_BITS = 16;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  // Request type codes.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_POP    = 1'b1;

  // One input item.
  typedef struct packed {
    logic req_type;
    key_t key;
    tag_t tag;
  } req_t;

  // One result item.
  typedef struct packed {
    logic pop_valid;
    key_t pop_key;
    tag_t pop_tag;
    key_t top_key;
    tag_t top_tag;
    logic is_empty;
    cnt_t entry_count;
    logic overflow;
  } res_t;

  // One heap entry as stored in memory.
  typedef struct packed {
    key_t key;
    tag_t tag;
  } entry_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_LD,
    ST_DN_CHK,
    ST_DN_RDR,
    ST_DN_CMP
  } state_t;

  // Read address select.
  typedef enum logic [1:0] {
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  // Write data select.
  typedef enum logic [1:0] {
    WR_MOVING,
    WR_PARENT,
    WR_PICK
  } wr_sel_t;

  // Kind of result to report.
  typedef enum logic [1:0] {
    RK_PLAIN,
    RK_POP,
    RK_OVF
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      ld_ins;
    logic      ld_pop;
    logic      ld_last;
    logic      ld_left;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      res;
    res_kind_t res_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_one;
    logic at_root;
    logic no_child;
    logic has_right;
    logic up_less;
    logic dn_less;
  } stat_t;

endpackage

[rtl/bhq_ctrl.sv]
// Controller state machine that sequences insert sift-up and pop sift-down.
module bhq_ctrl import bhq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  req_type,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.rd_sel   = RD_PARENT;
    cmd.wr_sel   = WR_MOVING;
    cmd.res_kind = RK_PLAIN;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (req_type == REQ_INSERT) begin
            if (stat.full) begin
              cmd.res      = 1'b1;
              cmd.res_kind = RK_OVF;
            end else begin
              cmd.ld_ins = 1'b1;
              state_next = ST_UP_CHK;
            end
          end else begin
            if (stat.empty) begin
              cmd.res = 1'b1;
            end else begin
              cmd.ld_pop = 1'b1;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_LAST;
              state_next = ST_POP_LD;
            end
          end
        end
      end
      // Insert: stop at the root, otherwise fetch the parent.
      ST_UP_CHK: begin
        if (stat.at_root) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_MOVING;
          cmd.res    = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PARENT;
          state_next = ST_UP_CMP;
        end
      end
      // Insert: move the parent down into the hole or settle the new item.
      ST_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.up_less) begin
          cmd.wr_sel = WR_PARENT;
          state_next = ST_UP_CHK;
        end else begin
          cmd.wr_sel = WR_MOVING;
          cmd.res    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      // Pop: the last entry becomes the item that sinks from the root; a pop of the only entry ends here.
      ST_POP_LD: begin
        cmd.ld_last = 1'b1;
        if (stat.cnt_one) begin
          cmd.res      = 1'b1;
          cmd.res_kind = RK_POP;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_DN_CHK;
        end
      end
      // Pop: stop at a leaf, otherwise fetch the left child.
      ST_DN_CHK: begin
        if (stat.no_child) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_MOVING;
          cmd.res      = 1'b1;
          cmd.res_kind = RK_POP;
          state_next   = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = ST_DN_RDR;
        end
      end
      // Pop: latch the left child and fetch the right one if present.
      ST_DN_RDR: begin
        cmd.ld_left = 1'b1;
        if (stat.has_right) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_RIGHT;
        end
        state_next = ST_DN_CMP;
      end
      // Pop: move the chosen child up into the hole or settle the item.
      ST_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat.dn_less) begin
          cmd.wr_sel = WR_PICK;
          state_next = ST_DN_CHK;
        end else begin
          cmd.wr_sel   = WR_MOVING;
          cmd.res      = 1'b1;
          cmd.res_kind = RK_POP;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/bhq_datapath.sv]
// Heap memory, position and count registers, comparators and result register.
module bhq_datapath import bhq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  done,
  output res_t  result
);

  entry_t mem [CAPACITY];

  cnt_t   cnt;
  cnt_t   cnt_next;
  cnt_t   pos;
  entry_t moving;
  entry_t lnode;
  entry_t root;
  entry_t root_next;
  entry_t popped;
  entry_t rdata;

  logic [CNT_W:0] lc;
  logic [CNT_W:0] rc;
  logic           pick_right;
  entry_t         pick;
  cnt_t           pick_idx;
  cnt_t           rd_idx;
  addr_t          rd_addr;
  addr_t          wr_addr;
  entry_t         wr_data;

  // Child positions of the hole.
  assign lc = {pos, 1'b0};
  assign rc = {pos, 1'b1};

  // Child choice: left if there is no right child or if it is strictly smaller than the right.
  assign pick_right = stat.has_right && !(lnode.key < rdata.key);
  assign pick       = pick_right ? rdata : lnode;
  assign pick_idx   = pick_right ? rc[CNT_W-1:0] : lc[CNT_W-1:0];

  // Status back to the controller.
  assign stat.full      = (cnt == cnt_t'(CAPACITY));
  assign stat.empty     = (cnt == '0);
  assign stat.cnt_one   = (cnt == cnt_t'(1));
  assign stat.at_root   = (pos == cnt_t'(1));
  assign stat.no_child  = (lc > {1'b0, cnt});
  assign stat.has_right = (rc <= {1'b0, cnt});
  assign stat.up_less   = (moving.key < rdata.key);
  assign stat.dn_less   = (pick.key < moving.key);

  // Read address select; heap positions start at one.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_PARENT: rd_idx = pos >> 1;
      RD_LAST:   rd_idx = cnt;
      RD_LEFT:   rd_idx = lc[CNT_W-1:0];
      RD_RIGHT:  rd_idx = rc[CNT_W-1:0];
      default:   rd_idx = pos;
    endcase
  end

  assign rd_addr = addr_t'(rd_idx - cnt_t'(1));
  assign wr_addr = addr_t'(pos - cnt_t'(1));

  // Write data select.
  always_comb begin
    unique case (cmd.wr_sel)
      WR_MOVING: wr_data = moving;
      WR_PARENT: wr_data = rdata;
      WR_PICK:   wr_data = pick;
      default:   wr_data = moving;
    endcase
  end

  // Heap memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Root copy and count as they stand after this cycle.
  assign root_next = (cmd.wr_en && stat.at_root) ? wr_data : root;

  always_comb begin
    cnt_next = cnt;
    if (cmd.ld_ins) begin
      cnt_next = cnt + cnt_t'(1);
    end else if (cmd.ld_last) begin
      cnt_next = cnt - cnt_t'(1);
    end
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Hole position, moving item, left child and popped entry.
  always_ff @(posedge clk) begin
    root <= root_next;
    if (cmd.ld_ins) begin
      pos        <= cnt + cnt_t'(1);
      moving.key <= req.key;
      moving.tag <= req.tag;
    end else if (cmd.ld_last) begin
      pos    <= cnt_t'(1);
      moving <= rdata;
    end else if (cmd.wr_en && cmd.wr_sel == WR_PARENT) begin
      pos <= pos >> 1;
    end else if (cmd.wr_en && cmd.wr_sel == WR_PICK) begin
      pos <= pick_idx;
    end
    if (cmd.ld_pop) begin
      popped <= root;
    end
    if (cmd.ld_left) begin
      lnode <= rdata;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res;
    end
  end

  // Result payload, built from the state left by the operation.
  always_ff @(posedge clk) begin
    if (cmd.res) begin
      result.pop_valid   <= (cmd.res_kind == RK_POP);
      result.pop_key     <= (cmd.res_kind == RK_POP) ? popped.key : '0;
      result.pop_tag     <= (cmd.res_kind == RK_POP) ? popped.tag : '0;
      result.top_key     <= (cnt_next != '0) ? root_next.key : '0;
      result.top_tag     <= (cnt_next != '0) ? root_next.tag : '0;
      result.is_empty    <= (cnt_next == '0);
      result.entry_count <= cnt_next;
      result.overflow    <= (cmd.res_kind == RK_OVF);
    end
  end

endmodule

[rtl/binary_min_heap_queue_top.sv]
// Top level of the binary min-heap priority queue: controller plus datapath.
// Each item is an insert or a pop of a (key, tag) entry, taken when start is high
// and busy is low, and gives exactly one result, shown for one cycle with done
// high; the receiver cannot stall it. All heap entries live in one memory with a
// single write port and a single registered read port, and that read port sets
// the rate. Busy stays high until the done cycle, so the next item can be taken
// in that cycle. A pop on an empty heap or an insert into a full heap shows its
// result in the cycle after acceptance and never raises busy.
module binary_min_heap_queue_top import bhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output res_t result
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for sift-up and sift-down.
  bhq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // Heap storage and arithmetic.
  bhq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

[tb/sv/tb_binary_min_heap_queue_top.sv]
// Self-checking testbench for the binary min-heap priority queue top level.
module tb_binary_min_heap_queue_top;
  import bhq_pkg::*;

  // One row of stimulus: the item and, where it is obvious, its result.
  typedef struct packed {
    req_t req;
    logic has_exp;
    res_t exp;
  } heap_row_t;

  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  res_t result;

  // Stimulus, predicted results and the predictor's own heap.
  heap_row_t stim_rows[$];
  res_t      result_queue[$];
  entry_t    heap_mem[1:CAPACITY];
  int        heap_fill = 0;
  int        gen_fill = 0;

  int   stim_pos = 0;
  int   burst_left = 0;
  int   idle_left = 0;
  int   stall_cycles = 0;
  int   mismatches = 0;
  logic took_item;
  logic next_start;
  logic timed_out;
  res_t want;

  binary_min_heap_queue_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always #10 clk = ~clk;

  // Apply one insert or pop to the predicted heap and return its result item.
  function automatic res_t heap_apply(req_t r);
    res_t   o;
    entry_t tmp;
    int     pos;
    int     kid;
    logic   moving;
    o = '0;
    if (r.req_type == REQ_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        o.overflow = 1'b1;
      end else begin
        heap_fill++;
        heap_mem[heap_fill].key = r.key;
        heap_mem[heap_fill].tag = r.tag;
        // Climb only while strictly below the parent.
        pos = heap_fill;
        moving = 1'b1;
        while (moving && pos > 1) begin
          if (heap_mem[pos].key < heap_mem[pos / 2].key) begin
            tmp = heap_mem[pos];
            heap_mem[pos] = heap_mem[pos / 2];
            heap_mem[pos / 2] = tmp;
            pos = pos / 2;
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else if (heap_fill > 0) begin
      o.pop_valid = 1'b1;
      o.pop_key = heap_mem[1].key;
      o.pop_tag = heap_mem[1].tag;
      heap_mem[1] = heap_mem[heap_fill];
      heap_fill--;
      // Sink the moved entry; ties between children go to the right one.
      pos = 1;
      moving = 1'b1;
      while (moving && 2 * pos <= heap_fill) begin
        kid = 2 * pos;
        if (kid + 1 <= heap_fill && !(heap_mem[kid].key < heap_mem[kid + 1].key)) begin
          kid = kid + 1;
        end
        if (heap_mem[kid].key < heap_mem[pos].key) begin
          tmp = heap_mem[kid];
          heap_mem[kid] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = kid;
        end else begin
          moving = 1'b0;
        end
      end
    end
    if (heap_fill > 0) begin
      o.top_key = heap_mem[1].key;
      o.top_tag = heap_mem[1].tag;
    end
    o.is_empty = (heap_fill == 0);
    o.entry_count = cnt_t'(heap_fill);
    return o;
  endfunction

  function automatic res_t make_res(logic pv, key_t pk, tag_t pt, key_t tk, tag_t tt,
                                    logic emp, int cnt, logic ovf);
    res_t o;
    o.pop_valid = pv;
    o.pop_key = pk;
    o.pop_tag = pt;
    o.top_key = tk;
    o.top_tag = tt;
    o.is_empty = emp;
    o.entry_count = cnt_t'(cnt);
    o.overflow = ovf;
    return o;
  endfunction

  // Keys lean toward a narrow band so that equal keys meet often.
  function automatic key_t rand_key();
    key_t k;
    case ($urandom_range(0, 9)) inside
      [0:3]: k = key_t'($urandom_range(0, 15));
      4: k = ($urandom_range(0, 1) == 1) ? '1 : '0;
      5: k = ~key_t'($urandom_range(0, 15));
      default: k = key_t'($urandom());
    endcase
    return k;
  endfunction

  task automatic add_item(logic op, key_t k, tag_t t);
    heap_row_t row;
    row = '0;
    row.req.req_type = op;
    row.req.key = k;
    row.req.tag = t;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic add_checked(logic op, key_t k, tag_t t, res_t e);
    heap_row_t row;
    row.req.req_type = op;
    row.req.key = k;
    row.req.tag = t;
    row.has_exp = 1'b1;
    row.exp = e;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  // Random item with the given insert percentage; tracks a rough fill level.
  task automatic add_random(int insert_pct);
    logic op;
    op = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
    add_item(op, rand_key(), tag_t'($urandom_range(0, 65535)));
    if (op == REQ_INSERT) begin
      if (gen_fill < CAPACITY) gen_fill++;
    end else if (gen_fill > 0) begin
      gen_fill--;
    end
  endtask

  // Check results, predict accepted items and drive the next item.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;

      // Each result is compared with the oldest prediction.
      if (done) begin
        if (result_queue.size() == 0) begin
          $error("result with no item outstanding");
          mismatches++;
        end else begin
          want = result_queue.pop_front();
          if (result.pop_valid !== want.pop_valid) begin
            $error("pop_valid: expected %0h, got %0h", want.pop_valid, result.pop_valid);
            mismatches++;
          end
          if (result.pop_key !== want.pop_key) begin
            $error("pop_key: expected %0h, got %0h", want.pop_key, result.pop_key);
            mismatches++;
          end
          if (result.pop_tag !== want.pop_tag) begin
            $error("pop_tag: expected %0h, got %0h", want.pop_tag, result.pop_tag);
            mismatches++;
          end
          if (result.top_key !== want.top_key) begin
            $error("top_key: expected %0h, got %0h", want.top_key, result.top_key);
            mismatches++;
          end
          if (result.top_tag !== want.top_tag) begin
            $error("top_tag: expected %0h, got %0h", want.top_tag, result.top_tag);
            mismatches++;
          end
          if (result.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0h, got %0h", want.is_empty, result.is_empty);
            mismatches++;
          end
          if (result.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   result.entry_count);
            mismatches++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0h, got %0h", want.overflow, result.overflow);
            mismatches++;
          end
        end
      end

      // An accepted item always updates the predicted heap.
      took_item = start && !busy;
      if (took_item) begin
        want = heap_apply(stim_rows[stim_pos].req);
        result_queue.insert(result_queue.size(),
                            stim_rows[stim_pos].has_exp ? stim_rows[stim_pos].exp : want);
        stim_pos++;
        stall_cycles = 0;
        if (burst_left > 0) burst_left--;
      end

      // Present the next item unless a gap between bursts is running.
      if (took_item || !start) begin
        if (burst_left == 0 && idle_left == 0) begin
          burst_left = $urandom_range(1, 16);
          idle_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
        if (idle_left > 0) begin
          idle_left--;
          next_start = 1'b0;
        end else if (stim_pos < stim_rows.size()) begin
          next_start = 1'b1;
          req <= stim_rows[stim_pos].req;
        end else begin
          next_start = 1'b0;
        end
        start <= next_start;
      end
    end
  end

  initial begin
    // Directed: empty pops, key extremes, equal keys on the way up and down.
    add_checked(REQ_POP, '1, '1, make_res(1'b0, '0, '0, '0, '0, 1'b1, 0, 1'b0));
    add_checked(REQ_INSERT, '1, '1, make_res(1'b0, '0, '0, '1, '1, 1'b0, 1, 1'b0));
    add_checked(REQ_INSERT, '0, '0, make_res(1'b0, '0, '0, '0, '0, 1'b0, 2, 1'b0));
    add_checked(REQ_INSERT, '0, 16'h1234,
                make_res(1'b0, '0, '0, '0, '0, 1'b0, 3, 1'b0));
    add_checked(REQ_POP, '0, '0, make_res(1'b1, '0, '0, '0, 16'h1234, 1'b0, 2, 1'b0));
    add_checked(REQ_POP, '0, '0, make_res(1'b1, '0, 16'h1234, '1, '1, 1'b0, 1, 1'b0));
    add_checked(REQ_POP, '0, '0, make_res(1'b1, '1, '1, '0, '0, 1'b1, 0, 1'b0));
    add_checked(REQ_POP, 32'h5555_5555, 16'hAAAA,
                make_res(1'b0, '0, '0, '0, '0, 1'b1, 0, 1'b0));
    add_item(REQ_INSERT, 32'd5, 16'h00A1);
    add_item(REQ_INSERT, 32'd5, 16'h00A2);
    add_item(REQ_INSERT, 32'd5, 16'h00A3);
    add_item(REQ_INSERT, 32'd7, 16'h00B0);
    add_item(REQ_INSERT, 32'd5, 16'h00A4);
    add_item(REQ_INSERT, 32'd3, 16'h00C0);
    add_item(REQ_INSERT, 32'hAAAA_AAAA, 16'h5555);
    for (int i = 0; i < 8; i++) begin
      add_item(REQ_POP, 32'hAAAA_AAAA, 16'h5555);
    end

    // Random: a mixed phase near empty, a fill to capacity with overflowing
    // inserts, then a pop-heavy drain through deep sift-downs.
    gen_fill = 0;
    for (int i = 0; i < 200; i++) add_random(55);
    while (gen_fill < CAPACITY) add_random(97);
    for (int i = 0; i < 8; i++) add_random((i == 3) ? 0 : 100);
    for (int i = 0; i < 230; i++) add_random(15);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every item and result, unless the block stops responding.
    timed_out = 1'b0;
    while (!timed_out && (stim_pos < stim_rows.size() || result_queue.size() != 0)) begin
      @(negedge clk);
      timed_out = (stall_cycles >= STALL_LIMIT);
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);
    if (result_queue.size() != 0) begin
      $error("%0d results never arrived", result_queue.size());
      mismatches++;
    end

    if (!timed_out && mismatches == 0) begin
      $display("tb_binary_min_heap_queue_top OK");
    end else begin
      $display("tb_binary_min_heap_queue_top NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bhq_pkg.sv
rtl/bhq_ctrl.sv
rtl/bhq_datapath.sv
rtl/binary_min_heap_queue_top.sv
tb/sv/tb_binary_min_heap_queue_top.sv
